// File: rtl/mfru_pkg.sv
// ----------------------------------------------------------------------------
// mfru_pkg
// Shared types and constants for the marker framed RGB565 unpacker.
// ----------------------------------------------------------------------------
package mfru_pkg;

    localparam int MARKER_BYTES_DEF = 6;
    localparam int MARKER_W         = 48;
    localparam int LEN_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int COUNT_W          = LEN_W + 1;
    localparam int FRAME_W          = 8;
    localparam int CHAN_W           = 8;

    localparam logic [MARKER_W-1:0] MARKER_RST = 48'h5374_6172_7420;
    localparam logic [LEN_W-1:0]    LEN_RST    = 16'd4800;
    localparam logic                MARK_RST   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK   = 2'd2;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

    typedef struct packed {
        logic [MARKER_W-1:0] marker_word;
        logic [LEN_W-1:0]    frame_pixels;
        logic                mark_enable;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [LEN_W-1:0]   index;
        logic [FRAME_W-1:0] frame;
        logic               last;
    } t_pixel;

endpackage

// File: rtl/mfru_cfg.sv
// ----------------------------------------------------------------------------
// mfru_cfg
// Configuration register file: marker word, frame length and mark enable.
// ----------------------------------------------------------------------------
module mfru_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [mfru_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mfru_pkg::MARKER_W-1:0]  i_cfg_data,
    output logic                           o_cfg_ready,
    output mfru_pkg::t_cfg                 o_cfg
);
    import mfru_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.marker_word  <= MARKER_RST;
            r_cfg.frame_pixels <= LEN_RST;
            r_cfg.mark_enable  <= MARK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MARKER: r_cfg.marker_word  <= i_cfg_data;
                CFG_LEN:    r_cfg.frame_pixels <= i_cfg_data[LEN_W-1:0];
                CFG_MARK:   r_cfg.mark_enable  <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

endmodule

// File: rtl/mfru_core.sv
// ----------------------------------------------------------------------------
// mfru_core
// Input byte register, marker search, pixel assembly and frame tracking.
// ----------------------------------------------------------------------------
module mfru_core #(
    parameter int MARKER_BYTES = mfru_pkg::MARKER_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [mfru_pkg::CHAN_W-1:0] i_data_byte,
    output logic                        o_stall,
    input  mfru_pkg::t_cfg              i_cfg,
    input  logic                        i_slot_free,
    output logic                        o_res_load,
    output mfru_pkg::t_pixel            o_res
);
    import mfru_pkg::*;

    localparam int WIN_W  = 8 * MARKER_BYTES;
    localparam int FILL_W = (MARKER_BYTES > 1) ? $clog2(MARKER_BYTES) : 1;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MARKER_BYTES - 1);

    logic               r_in_valid;
    logic [CHAN_W-1:0]  r_in_byte;
    logic [WIN_W-1:0]   r_recent;
    logic [FILL_W-1:0]  r_fill;
    logic               r_in_frame;
    logic [COUNT_W-1:0] r_count;
    logic [CHAN_W-1:0]  r_high;
    logic [FRAME_W-1:0] r_frame;

    logic [WIN_W-1:0]   n_recent;
    logic [FILL_W-1:0]  n_fill;
    logic               n_in_frame;
    logic [COUNT_W-1:0] n_count;
    logic [CHAN_W-1:0]  n_high;
    logic [FRAME_W-1:0] n_frame;

    logic [63:0]        marker_ext;
    logic [WIN_W-1:0]   marker_cmp;
    logic [WIN_W-1:0]   win;
    logic               match;
    logic               res_valid;
    logic               advance;
    logic [LEN_W-1:0]   idx;
    logic [LEN_W-1:0]   last_idx;
    logic               last;
    t_pixel             res;

    assign advance    = r_in_valid && (!res_valid || i_slot_free);
    assign o_stall    = r_in_valid && !advance;
    assign o_res_load = advance && res_valid;
    assign o_res      = res;

    assign marker_ext = {{(64 - MARKER_W){1'b0}}, i_cfg.marker_word};
    assign marker_cmp = marker_ext[WIN_W-1:0];
    assign win        = (r_recent << 8) | WIN_W'(r_in_byte);
    assign match      = (r_fill == FILL_FULL) && (win == marker_cmp);
    assign idx        = r_count[COUNT_W-1:1];
    assign last_idx   = i_cfg.frame_pixels - LEN_W'(1);
    assign last       = (idx == last_idx);
    assign res_valid  = r_in_frame && r_count[0];

    always_comb begin
        n_recent   = r_recent;
        n_fill     = r_fill;
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_high     = r_high;
        n_frame    = r_frame;

        res.red   = {r_high[7:3], 3'b000};
        res.green = {r_high[2:0], r_in_byte[7:5], 2'b00};
        res.blue  = {r_in_byte[4:0], 3'b000};
        res.index = idx;
        res.frame = r_frame;
        res.last  = last;
        if (i_cfg.mark_enable) begin
            if (idx == LEN_W'(0)) begin
                res.red = CHAN_FULL; res.green = CHAN_ZERO; res.blue = CHAN_ZERO;
            end else if (idx == LEN_W'(1)) begin
                res.red = CHAN_ZERO; res.green = CHAN_FULL; res.blue = CHAN_ZERO;
            end else if (idx == LEN_W'(2)) begin
                res.red = CHAN_ZERO; res.green = CHAN_ZERO; res.blue = CHAN_FULL;
            end
        end

        if (!r_in_frame) begin
            if (match) begin
                n_in_frame = 1'b1;
                n_count    = '0;
                n_recent   = '0;
                n_fill     = '0;
            end else begin
                n_recent = win;
                if (r_fill != FILL_FULL) begin
                    n_fill = r_fill + FILL_W'(1);
                end
            end
        end else if (!r_count[0]) begin
            n_high  = r_in_byte;
            n_count = r_count + COUNT_W'(1);
        end else begin
            n_count = r_count + COUNT_W'(1);
            if (last) begin
                n_in_frame = 1'b0;
                n_count    = '0;
                n_recent   = '0;
                n_fill     = '0;
                n_frame    = r_frame + FRAME_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent   <= '0;
            r_fill     <= '0;
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_high     <= '0;
            r_frame    <= '0;
        end else if (advance) begin
            r_recent   <= n_recent;
            r_fill     <= n_fill;
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_high     <= n_high;
            r_frame    <= n_frame;
        end
    end

endmodule

// File: rtl/mfru_out.sv
// ----------------------------------------------------------------------------
// mfru_out
// Result register holding one widened pixel until the consumer takes it.
// ----------------------------------------------------------------------------
module mfru_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mfru_pkg::t_pixel i_res,
    input  logic             i_stall,
    output logic             o_slot_free,
    output logic             o_valid,
    output mfru_pkg::t_pixel o_res
);
    import mfru_pkg::*;

    logic   r_valid;
    t_pixel r_res;

    assign o_slot_free = !r_valid || !i_stall;
    assign o_valid     = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: rtl/marker_framed_rgb565_unpacker.sv
// ----------------------------------------------------------------------------
// marker_framed_rgb565_unpacker
// Finds a start marker in a byte stream and unpacks the following RGB565
// pixels of each frame into 8-bit channels.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while o_stall is low and emits one
// pixel beat for every second payload byte; the byte that completes a pixel
// passes through the input byte register and then the result register.
// Configuration writes are taken in every cycle and should be made while no
// bytes are in flight.
module marker_framed_rgb565_unpacker #(
    parameter int MARKER_BYTES = mfru_pkg::MARKER_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [7:0]                     i_data_byte,
    output logic                           o_stall,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_red_out,
    output logic [7:0]                     o_green_out,
    output logic [7:0]                     o_blue_out,
    output logic [15:0]                    o_pixel_index,
    output logic [7:0]                     o_frame_number,
    output logic                           o_last_pixel,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mfru_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mfru_pkg::MARKER_W-1:0]  i_cfg_data
);
    import mfru_pkg::*;

    t_cfg   cfg;
    t_pixel res;
    t_pixel out_res;
    logic   res_load;
    logic   slot_free;

    mfru_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    mfru_core #(
        .MARKER_BYTES (MARKER_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .o_stall     (o_stall),
        .i_cfg       (cfg),
        .i_slot_free (slot_free),
        .o_res_load  (res_load),
        .o_res       (res)
    );

    mfru_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_load),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_slot_free (slot_free),
        .o_valid     (o_valid),
        .o_res       (out_res)
    );

    assign o_red_out      = out_res.red;
    assign o_green_out    = out_res.green;
    assign o_blue_out     = out_res.blue;
    assign o_pixel_index  = out_res.index;
    assign o_frame_number = out_res.frame;
    assign o_last_pixel   = out_res.last;

endmodule

// File: verif/marker_framed_rgb565_unpacker_tb.sv
// ----------------------------------------------------------------------------
// marker_framed_rgb565_unpacker_tb
// Self-checking testbench for the marker framed RGB565 unpacker. A byte-level
// model of the block tracks the marker search, the payload count and the
// frame number, and queues one expected pixel beat for every completed pixel.
// A monitor compares each accepted pixel beat field by field with the oldest
// queued pixel. Directed tests cover register reset values, marker search
// corner cases, channel extremes, output back pressure, frame number wrap,
// zero frame length and a length cut inside a frame. Random frames follow,
// first with random idle bursts on both sides and then without them.
// ----------------------------------------------------------------------------
module marker_framed_rgb565_unpacker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfru_pkg::*;

    localparam int MARKER_LEN = MARKER_BYTES_DEF;
    localparam logic [63:0] WINDOW_MASK = {64{1'b1}} >> (64 - 8 * MARKER_LEN);
    localparam logic [63:0] HISTORY_MASK = (64'd1 << (8 * (MARKER_LEN - 1))) - 64'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic [7:0]           i_data_byte;
    logic                 o_stall;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [7:0]           o_red_out;
    logic [7:0]           o_green_out;
    logic [7:0]           o_blue_out;
    logic [15:0]          o_pixel_index;
    logic [7:0]           o_frame_number;
    logic                 o_last_pixel;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MARKER_W-1:0]  i_cfg_data;

    logic [MARKER_W-1:0] marker_cfg = MARKER_RST;
    logic [LEN_W-1:0]    length_cfg = LEN_RST;
    logic                mark_cfg = MARK_RST;

    logic [63:0]        search_hist = '0;
    int                 hist_fill = 0;
    logic               in_payload = 1'b0;
    logic [COUNT_W-1:0] payload_bytes = '0;
    logic [7:0]         pending_high = '0;
    logic [FRAME_W-1:0] frame_count = '0;
    int                 payload_taken = 0;

    t_pixel pixels_due[$];
    int     mismatches = 0;

    logic tx_idle = 1'b0;
    logic rx_idle = 1'b0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   stall_left = 0;

    marker_framed_rgb565_unpacker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_data_byte    (i_data_byte),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_pixel_index  (o_pixel_index),
        .o_frame_number (o_frame_number),
        .o_last_pixel   (o_last_pixel),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("marker_framed_rgb565_unpacker verification failed");
        $finish;
    end

    task automatic advance_unpacker(input logic [7:0] value);
        logic [63:0] window;
        logic [15:0] pix;
        logic [15:0] idx;
        logic [15:0] last_idx;
        t_pixel      px;
        if (!in_payload) begin
            window = ((search_hist << 8) | {56'h0, value}) & WINDOW_MASK;
            if (hist_fill >= MARKER_LEN - 1 &&
                window == ({16'h0, marker_cfg} & WINDOW_MASK)) begin
                in_payload = 1'b1;
                payload_bytes = '0;
                search_hist = '0;
                hist_fill = 0;
            end else begin
                search_hist = window & HISTORY_MASK;
                if (hist_fill < MARKER_LEN - 1) hist_fill++;
            end
        end else if (!payload_bytes[0]) begin
            pending_high = value;
            payload_bytes = payload_bytes + COUNT_W'(1);
            payload_taken++;
        end else begin
            pix = {pending_high, value};
            idx = payload_bytes[16:1];
            last_idx = length_cfg - 16'd1;
            px.red = {pix[15:11], 3'b000};
            px.green = {pix[10:5], 2'b00};
            px.blue = {pix[4:0], 3'b000};
            if (mark_cfg) begin
                case (idx)
                    16'd0: begin
                        px.red = CHAN_FULL; px.green = CHAN_ZERO; px.blue = CHAN_ZERO;
                    end
                    16'd1: begin
                        px.red = CHAN_ZERO; px.green = CHAN_FULL; px.blue = CHAN_ZERO;
                    end
                    16'd2: begin
                        px.red = CHAN_ZERO; px.green = CHAN_ZERO; px.blue = CHAN_FULL;
                    end
                    default: ;
                endcase
            end
            px.index = idx;
            px.frame = frame_count;
            px.last = (idx == last_idx);
            pixels_due.push_back(px);
            payload_bytes = payload_bytes + COUNT_W'(1);
            payload_taken++;
            if (px.last) begin
                in_payload = 1'b0;
                payload_bytes = '0;
                search_hist = '0;
                hist_fill = 0;
                frame_count = frame_count + FRAME_W'(1);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : pixel_monitor
        t_pixel want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pixels_due.size() == 0) begin
                $error("unexpected pixel beat with pixel_index %0d", o_pixel_index);
                mismatches++;
            end else begin
                want = pixels_due.pop_front();
                compare_field("red_out", 16'(want.red), 16'(o_red_out));
                compare_field("green_out", 16'(want.green), 16'(o_green_out));
                compare_field("blue_out", 16'(want.blue), 16'(o_blue_out));
                compare_field("pixel_index", want.index, o_pixel_index);
                compare_field("frame_number", 16'(want.frame), 16'(o_frame_number));
                compare_field("last_pixel", 16'(want.last), 16'(o_last_pixel));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            stall_left <= HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 18);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= value;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        advance_unpacker(value);
    endtask

    task automatic send_pixel(input logic [15:0] pix);
        send_byte(pix[15:8]);
        send_byte(pix[7:0]);
    endtask

    task automatic send_marker_head(input int count);
        for (int k = 0; k < count; k++) begin
            send_byte(marker_cfg[8 * (MARKER_LEN - 1 - k) +: 8]);
        end
    endtask

    task automatic finish_frame();
        while (in_payload) send_byte(8'($urandom));
    endtask

    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [MARKER_W-1:0] value);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_MARKER: marker_cfg = value;
            CFG_LEN:    length_cfg = value[LEN_W-1:0];
            CFG_MARK:   mark_cfg = value[0];
            default: ;
        endcase
    endtask

    task automatic set_frame_length(input int pixels);
        write_register(CFG_LEN, {32'($urandom), 16'(pixels)});
    endtask

    task automatic set_marking(input logic on);
        write_register(CFG_MARK, {47'($urandom), on});
    endtask

    task automatic test_reset_values();
        send_marker_head(3);
        send_byte(8'h00);
        send_marker_head(MARKER_LEN);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hF800);
        send_pixel(16'h07E0);
        send_pixel(16'h001F);
        set_frame_length(8);
        finish_frame();
    endtask

    task automatic test_marker_search();
        set_marking(1'b0);
        set_frame_length(1);
        write_register(CFG_MARKER, '0);
        repeat (MARKER_LEN) send_byte(8'h00);
        send_pixel(16'h1234);
        write_register(CFG_MARKER, '1);
        repeat (MARKER_LEN + 1) send_byte(8'hFF);
        send_byte(8'h00);
        write_register(CFG_MARKER, MARKER_RST);
        send_marker_head(1);
        send_marker_head(MARKER_LEN);
        send_pixel(16'hFFFF);
        send_marker_head(3);
        send_byte(8'h00);
        send_marker_head(MARKER_LEN);
        send_pixel(16'h8410);
        send_marker_head(MARKER_LEN);
        send_marker_head(2);
        for (int k = MARKER_LEN - 3; k >= 0; k--) send_byte(marker_cfg[8 * k +: 8]);
        send_marker_head(MARKER_LEN);
        send_pixel(16'h5555);
        write_register(CFG_SPARE, '1);
        send_marker_head(MARKER_LEN);
        send_pixel(16'hAAAA);
    endtask

    task automatic test_pixel_channels();
        set_frame_length(8);
        send_marker_head(MARKER_LEN);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hF800);
        send_pixel(16'h07E0);
        send_pixel(16'h001F);
        send_pixel(16'h8410);
        send_pixel(16'h5555);
        send_pixel(16'hAAAA);
        set_marking(1'b1);
        set_frame_length(4);
        send_marker_head(MARKER_LEN);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
    endtask

    task automatic test_output_backpressure();
        logic saved_idle;
        saved_idle = tx_idle;
        tx_idle = 1'b0;
        set_frame_length(40);
        hold_requests++;
        send_marker_head(MARKER_LEN);
        finish_frame();
        wait_quiet();
        tx_idle = saved_idle;
    endtask

    task automatic test_frame_counter_wrap();
        set_frame_length(1);
        do begin
            send_marker_head(MARKER_LEN);
            send_pixel(16'($urandom));
        end while (frame_count != FRAME_W'(1));
    endtask

    task automatic test_zero_length();
        set_marking(1'b0);
        set_frame_length(0);
        send_marker_head(MARKER_LEN);
        repeat (8) send_pixel(16'($urandom));
        set_frame_length(10);
        finish_frame();
    endtask

    task automatic test_length_cut();
        set_marking(1'b1);
        set_frame_length(65535);
        send_marker_head(MARKER_LEN);
        repeat (20) send_pixel(16'($urandom));
        set_frame_length(21);
        finish_frame();
    endtask

    task automatic test_random_frames(input int payload_goal);
        int goal;
        goal = payload_taken + payload_goal;
        while (payload_taken < goal) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 2))
                    0: write_register(CFG_MARKER, {16'($urandom), 32'($urandom)});
                    1: write_register(CFG_MARKER, {MARKER_LEN{8'($urandom)}});
                    default: ;
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    set_frame_length($urandom_range(13, 200));
                end else begin
                    set_frame_length($urandom_range(1, 12));
                end
                set_marking(1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(0, 6)) send_byte(8'($urandom));
            if ($urandom_range(0, 4) == 0) begin
                send_marker_head($urandom_range(1, MARKER_LEN - 1));
                send_byte(8'($urandom));
            end
            if ($urandom_range(0, 9) != 0) send_marker_head(MARKER_LEN);
            finish_frame();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data_byte <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_MARKER;
        i_cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_reset_values();
        test_marker_search();
        test_pixel_channels();
        test_output_backpressure();
        test_frame_counter_wrap();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_zero_length();
        test_length_cut();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_random_frames(150);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_frames(60);
        wait_quiet();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("marker_framed_rgb565_unpacker verification clean");
        end else begin
            $display("marker_framed_rgb565_unpacker verification failed");
        end
        $finish;
    end

endmodule
